### rtl/ptlp_pkg.sv
// shared constants for the point to line projection block
`timescale 1ns / 1ps
package ptlp_pkg;
   localparam int DEF_COORD_WIDTH = 32;
   localparam int DEF_FRAC_BITS   = 16;
   localparam int MIN_FRAC_BITS   = 8;
endpackage

### rtl/ptlp_chan_if.sv
// request and response channel interfaces of the projection block
`timescale 1ns / 1ps
interface ptlp_req_if import ptlp_pkg::*; #(parameter int CW = DEF_COORD_WIDTH) ();
   logic valid;
   logic ready;
   logic signed [CW-1:0] query_x;
   logic signed [CW-1:0] query_y;
   logic signed [CW-1:0] query_z;
   logic signed [CW-1:0] start_x;
   logic signed [CW-1:0] start_y;
   logic signed [CW-1:0] start_z;
   logic signed [CW-1:0] end_x;
   logic signed [CW-1:0] end_y;
   logic signed [CW-1:0] end_z;
   logic segment_only;
   modport source (output valid, query_x, query_y, query_z, start_x, start_y, start_z,
                   end_x, end_y, end_z, segment_only, input ready);
   modport sink (input valid, query_x, query_y, query_z, start_x, start_y, start_z,
                 end_x, end_y, end_z, segment_only, output ready);
endinterface

interface ptlp_rsp_if import ptlp_pkg::*; #(parameter int CW = DEF_COORD_WIDTH) ();
   logic valid;
   logic ready;
   logic signed [CW-1:0] line_param;
   logic signed [CW-1:0] near_x;
   logic signed [CW-1:0] near_y;
   logic signed [CW-1:0] near_z;
   logic near_valid;
   logic [CW-1:0] line_distance;
   logic degenerate;
   modport source (output valid, line_param, near_x, near_y, near_z, near_valid,
                   line_distance, degenerate, input ready);
   modport sink (input valid, line_param, near_x, near_y, near_z, near_valid,
                 line_distance, degenerate, output ready);
endinterface

### rtl/ptlp_div_cell.sv
// one restoring divider cell: one quotient bit per cell
`timescale 1ns / 1ps
module ptlp_div_cell import ptlp_pkg::*; #(
   parameter int DEN_W = 66,
   parameter int LO_W  = 32,
   parameter int Q_W   = 32,
   parameter int SB_W  = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             up_valid,
   input  logic [DEN_W-1:0] up_rem,
   input  logic [DEN_W-1:0] up_den,
   input  logic [LO_W-1:0]  up_lo,
   input  logic [Q_W-1:0]   up_quo,
   input  logic [SB_W-1:0]  up_side,
   output logic             dn_valid,
   output logic [DEN_W-1:0] dn_rem,
   output logic [DEN_W-1:0] dn_den,
   output logic [LO_W-1:0]  dn_lo,
   output logic [Q_W-1:0]   dn_quo,
   output logic [SB_W-1:0]  dn_side
);
   logic             valid_ff;
   logic [DEN_W-1:0] rem_ff, rem_in, den_ff;
   logic [LO_W-1:0]  lo_ff;
   logic [Q_W-1:0]   quo_ff, quo_in;
   logic [SB_W-1:0]  side_ff;
   logic [DEN_W:0]   shifted, diff;
   logic             fits;

   always_comb begin
      shifted = {up_rem, up_lo[LO_W-1]};
      diff    = shifted - {1'b0, up_den};
      fits    = shifted >= {1'b0, up_den};
      rem_in  = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo_in  = {up_quo[Q_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         den_ff  <= up_den;
         lo_ff   <= {up_lo[LO_W-2:0], 1'b0};
         quo_ff  <= quo_in;
         side_ff <= up_side;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_rem   = rem_ff;
   assign dn_den   = den_ff;
   assign dn_lo    = lo_ff;
   assign dn_quo   = quo_ff;
   assign dn_side  = side_ff;
endmodule

### rtl/ptlp_sqrt_cell.sv
// one square root cell: one root bit per cell from two radicand bits
`timescale 1ns / 1ps
module ptlp_sqrt_cell import ptlp_pkg::*; #(
   parameter int ROOT_W = 32,
   parameter int SB_W   = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                up_valid,
   input  logic [ROOT_W+1:0]   up_rem,
   input  logic [ROOT_W-1:0]   up_root,
   input  logic [2*ROOT_W-1:0] up_rad,
   input  logic [SB_W-1:0]     up_side,
   output logic                dn_valid,
   output logic [ROOT_W+1:0]   dn_rem,
   output logic [ROOT_W-1:0]   dn_root,
   output logic [2*ROOT_W-1:0] dn_rad,
   output logic [SB_W-1:0]     dn_side
);
   localparam int XW = 2 * ROOT_W;
   logic                valid_ff;
   logic [ROOT_W+1:0]   rem_ff, rem_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [XW-1:0]       rad_ff;
   logic [SB_W-1:0]     side_ff;
   logic [ROOT_W+3:0]   shifted, trial, diff;
   logic                fits;

   always_comb begin
      shifted = {up_rem, up_rad[XW-1:XW-2]};
      trial   = {2'b00, up_root, 2'b01};
      diff    = shifted - trial;
      fits    = shifted >= trial;
      rem_in  = fits ? diff[ROOT_W+1:0] : shifted[ROOT_W+1:0];
      root_in = {up_root[ROOT_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         rad_ff  <= {up_rad[XW-3:0], 2'b00};
         side_ff <= up_side;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_rem   = rem_ff;
   assign dn_root  = root_ff;
   assign dn_rad   = rad_ff;
   assign dn_side  = side_ff;
endmodule

### rtl/point_to_line_projection.sv
// top level: projection of a 3d point onto a line, fully pipelined
`timescale 1ns / 1ps
// Projects a query point onto the line through start and end, all signed fixed point with
// FRAC_BITS fraction bits, and returns the line parameter t (rounded half away from zero),
// the closest point, its validity under the segment rule, the floor of the distance to the
// line, and a degenerate flag when start equals end (all other results then zero). Every
// result saturates. One request is taken per clock unless the pipeline holds; each response
// passes through the stage registers and two chains of COORD_WIDTH cells: the
// divider (one quotient bit per cell) and the square root (one root bit per cell). The whole
// pipeline advances together and holds while a finished response waits, so req ready is low
// only when the output register is full and not being taken.
module point_to_line_projection import ptlp_pkg::*; #(
   parameter int COORD_WIDTH = DEF_COORD_WIDTH,
   parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
   input logic        clock,
   input logic        reset,
   ptlp_req_if.sink   req_chan,
   ptlp_rsp_if.source rsp_chan
);
   localparam int CW   = COORD_WIDTH;
   localparam int FB   = FRAC_BITS;
   localparam int DW   = CW + 1;           // differences
   localparam int PW   = 2 * DW;           // products
   localparam int SMW  = PW + 2;           // signed dot product
   localparam int DENW = 2 * CW + 2;       // squared length
   localparam int NW   = DENW + FB + 1;    // scaled, rounded dividend
   localparam int HIW  = NW - CW;
   localparam int CMPW = (HIW > DENW) ? HIW : DENW;
   localparam int DSB  = 6 * CW + 3 * DW + 4;
   localparam int P2W  = CW + DW + 1 - FB;
   localparam int MW   = (P2W > CW + 2) ? P2W : CW + 2;
   localparam int NSW  = CW + 3;
   localparam int QSB  = 4 * CW + 3;

   // whole pipeline moves when the output slot is free or being emptied
   logic adv;
   logic out_valid_ff;
   assign adv = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   // stage 1: differences d = end - start, w = query - start
   logic                 v1_ff;
   logic signed [CW-1:0] s1_q_ff [0:2];
   logic signed [CW-1:0] s1_s_ff [0:2];
   logic signed [DW-1:0] s1_d_ff [0:2];
   logic signed [DW-1:0] s1_w_ff [0:2];
   logic                 s1_seg_ff;
   logic signed [CW-1:0] in_q [0:2];
   logic signed [CW-1:0] in_s [0:2];
   logic signed [CW-1:0] in_e [0:2];

   assign in_q[0] = req_chan.query_x;
   assign in_q[1] = req_chan.query_y;
   assign in_q[2] = req_chan.query_z;
   assign in_s[0] = req_chan.start_x;
   assign in_s[1] = req_chan.start_y;
   assign in_s[2] = req_chan.start_z;
   assign in_e[0] = req_chan.end_x;
   assign in_e[1] = req_chan.end_y;
   assign in_e[2] = req_chan.end_z;

   // stage 2: the six products
   logic                 v2_ff;
   logic signed [CW-1:0] s2_q_ff [0:2];
   logic signed [CW-1:0] s2_s_ff [0:2];
   logic signed [DW-1:0] s2_d_ff [0:2];
   logic signed [PW-1:0] s2_wd_ff [0:2];
   logic [PW-1:0]        s2_dd_ff [0:2];
   logic                 s2_seg_ff;

   // stage 3: dot products
   logic                  v3_ff;
   logic signed [CW-1:0]  s3_q_ff [0:2];
   logic signed [CW-1:0]  s3_s_ff [0:2];
   logic signed [DW-1:0]  s3_d_ff [0:2];
   logic signed [SMW-1:0] s3_num_ff, s3_num_in;
   logic [DENW-1:0]       s3_den_ff, s3_den_in;
   logic                  s3_seg_ff;

   // stage 4: sign, magnitude, segment test, rounded dividend
   logic                 v4_ff;
   logic signed [CW-1:0] s4_q_ff [0:2];
   logic signed [CW-1:0] s4_s_ff [0:2];
   logic signed [DW-1:0] s4_d_ff [0:2];
   logic                 s4_neg_ff, s4_neg_in;
   logic                 s4_ok_ff, s4_ok_in;
   logic                 s4_degen_ff, s4_degen_in;
   logic [NW-1:0]        s4_dvd_ff, s4_dvd_in;
   logic [DENW-1:0]      s4_den_ff;
   logic [DENW-1:0]      nmag;
   logic signed [SMW-1:0] num_neg;

   // stage 5: quotient overflow check, first partial remainder
   logic                 v5_ff;
   logic [DENW-1:0]      s5_rem_ff, s5_den_ff;
   logic [CW-1:0]        s5_lo_ff;
   logic [DSB-1:0]       s5_side_ff, s5_side_in;
   logic                 s5_ovf_in;
   logic [HIW-1:0]       dvd_hi;

   // divider chain
   logic            dv_valid [0:CW];
   logic [DENW-1:0] dv_rem   [0:CW];
   logic [DENW-1:0] dv_den   [0:CW];
   logic [CW-1:0]   dv_lo    [0:CW];
   logic [CW-1:0]   dv_quo   [0:CW];
   logic [DSB-1:0]  dv_side  [0:CW];

   // divider sideband unpacked at its end
   logic signed [CW-1:0] dq_q [0:2];
   logic signed [CW-1:0] dq_s [0:2];
   logic signed [DW-1:0] dq_d [0:2];
   logic                 dq_ok, dq_neg, dq_degen, dq_ovf;

   // stage t: saturated line parameter
   logic                 vt_ff;
   logic signed [CW-1:0] st_q_ff [0:2];
   logic signed [CW-1:0] st_s_ff [0:2];
   logic signed [DW-1:0] st_d_ff [0:2];
   logic [CW-1:0]        st_mag_ff, st_mag_in;
   logic signed [CW-1:0] st_t_ff, st_t_in;
   logic                 st_neg_ff, st_ok_ff, st_degen_ff;
   logic [CW-1:0]        t_lim;

   // stage m: t * d
   logic                    vm_ff;
   logic signed [CW-1:0]    sm_q_ff [0:2];
   logic signed [CW-1:0]    sm_s_ff [0:2];
   logic                    sm_dneg_ff [0:2];
   logic [CW+DW-1:0]        sm_p_ff [0:2];
   logic signed [CW-1:0]    sm_t_ff;
   logic                    sm_neg_ff, sm_ok_ff, sm_degen_ff;
   logic [DW-1:0]           d_mag [0:2];

   // stage n: closest point
   logic                 vn_ff;
   logic signed [CW-1:0] sn_q_ff [0:2];
   logic signed [CW-1:0] sn_near_ff [0:2];
   logic signed [CW-1:0] sn_near_in [0:2];
   logic signed [CW-1:0] sn_t_ff;
   logic                 sn_ok_ff, sn_degen_ff;
   logic [CW+DW:0]       p_rnd [0:2];
   logic [MW-1:0]        off_ext [0:2];
   logic [CW+1:0]        off_mag [0:2];
   logic signed [NSW-1:0] near_sum [0:2];
   logic [MW-1:0]        off_cap;

   // stage e: squared errors
   logic                 ve_ff;
   logic [PW-1:0]        se_sq_ff [0:2];
   logic signed [CW-1:0] se_near_ff [0:2];
   logic signed [CW-1:0] se_t_ff;
   logic                 se_ok_ff, se_degen_ff;
   logic signed [DW-1:0] err [0:2];
   logic [DW-1:0]        err_mag [0:2];

   // stage d: squared distance, overflow of the root
   logic                 vd_ff;
   logic [2*CW-1:0]      sd_rad_ff;
   logic [QSB-1:0]       sd_side_ff;
   logic [PW+1:0]        dist2;

   // square root chain
   logic            sq_valid [0:CW];
   logic [CW+1:0]   sq_rem   [0:CW];
   logic [CW-1:0]   sq_root  [0:CW];
   logic [2*CW-1:0] sq_rad   [0:CW];
   logic [QSB-1:0]  sq_side  [0:CW];

   logic signed [CW-1:0] fq_t;
   logic signed [CW-1:0] fq_near [0:2];
   logic                 fq_ok, fq_degen, fq_sat;

   // output register
   logic signed [CW-1:0] out_t_ff;
   logic signed [CW-1:0] out_near_ff [0:2];
   logic                 out_ok_ff, out_degen_ff;
   logic [CW-1:0]        out_dist_ff;

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         vt_ff        <= 1'b0;
         vm_ff        <= 1'b0;
         vn_ff        <= 1'b0;
         ve_ff        <= 1'b0;
         vd_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= req_chan.valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         vt_ff        <= dv_valid[CW];
         vm_ff        <= vt_ff;
         vn_ff        <= vm_ff;
         ve_ff        <= vn_ff;
         vd_ff        <= ve_ff;
         out_valid_ff <= sq_valid[CW];
      end
   end

   // stages 1 to 4
   always_comb begin
      s3_num_in = SMW'(s2_wd_ff[0]) + SMW'(s2_wd_ff[1]) + SMW'(s2_wd_ff[2]);
      s3_den_in = s2_dd_ff[0] + s2_dd_ff[1] + s2_dd_ff[2];
      s4_neg_in = s3_num_ff[SMW-1];
      num_neg   = -s3_num_ff;
      nmag      = s4_neg_in ? num_neg[DENW-1:0] : s3_num_ff[DENW-1:0];
      // outside the segment means the exact quotient lies below 0 or above 1
      s4_ok_in    = !(s3_seg_ff && (s4_neg_in || nmag > s3_den_ff));
      s4_degen_in = s3_den_ff == '0;
      s4_dvd_in   = {1'b0, nmag, {FB{1'b0}}} + NW'(s3_den_ff >> 1);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            s1_q_ff[i]  <= in_q[i];
            s1_s_ff[i]  <= in_s[i];
            s1_d_ff[i]  <= DW'(in_e[i]) - DW'(in_s[i]);
            s1_w_ff[i]  <= DW'(in_q[i]) - DW'(in_s[i]);
            s2_q_ff[i]  <= s1_q_ff[i];
            s2_s_ff[i]  <= s1_s_ff[i];
            s2_d_ff[i]  <= s1_d_ff[i];
            s2_wd_ff[i] <= PW'(s1_w_ff[i]) * PW'(s1_d_ff[i]);
            s2_dd_ff[i] <= PW'(s1_d_ff[i]) * PW'(s1_d_ff[i]);
            s3_q_ff[i]  <= s2_q_ff[i];
            s3_s_ff[i]  <= s2_s_ff[i];
            s3_d_ff[i]  <= s2_d_ff[i];
            s4_q_ff[i]  <= s3_q_ff[i];
            s4_s_ff[i]  <= s3_s_ff[i];
            s4_d_ff[i]  <= s3_d_ff[i];
         end
         s1_seg_ff   <= req_chan.segment_only;
         s2_seg_ff   <= s1_seg_ff;
         s3_seg_ff   <= s2_seg_ff;
         s3_num_ff   <= s3_num_in;
         s3_den_ff   <= s3_den_in;
         s4_neg_ff   <= s4_neg_in;
         s4_ok_ff    <= s4_ok_in;
         s4_degen_ff <= s4_degen_in;
         s4_dvd_ff   <= s4_dvd_in;
         s4_den_ff   <= s3_den_ff;
      end
   end

   // stage 5: a quotient of 2^CW or more saturates, the rest is divided bit by bit
   always_comb begin
      dvd_hi     = s4_dvd_ff[NW-1:CW];
      s5_ovf_in  = CMPW'(dvd_hi) >= CMPW'(s4_den_ff);
      s5_side_in = {s4_q_ff[0], s4_q_ff[1], s4_q_ff[2], s4_s_ff[0], s4_s_ff[1], s4_s_ff[2],
                    s4_d_ff[0], s4_d_ff[1], s4_d_ff[2], s4_ok_ff, s4_neg_ff, s4_degen_ff,
                    s5_ovf_in};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_rem_ff  <= DENW'(dvd_hi);
         s5_den_ff  <= s4_den_ff;
         s5_lo_ff   <= s4_dvd_ff[CW-1:0];
         s5_side_ff <= s5_side_in;
      end
   end

   assign dv_valid[0] = v5_ff;
   assign dv_rem[0]   = s5_rem_ff;
   assign dv_den[0]   = s5_den_ff;
   assign dv_lo[0]    = s5_lo_ff;
   assign dv_quo[0]   = '0;
   assign dv_side[0]  = s5_side_ff;

   for (genvar k = 0; k < CW; k++) begin : g_div
      ptlp_div_cell #(.DEN_W(DENW), .LO_W(CW), .Q_W(CW), .SB_W(DSB)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (adv),
         .up_valid (dv_valid[k]),
         .up_rem   (dv_rem[k]),
         .up_den   (dv_den[k]),
         .up_lo    (dv_lo[k]),
         .up_quo   (dv_quo[k]),
         .up_side  (dv_side[k]),
         .dn_valid (dv_valid[k+1]),
         .dn_rem   (dv_rem[k+1]),
         .dn_den   (dv_den[k+1]),
         .dn_lo    (dv_lo[k+1]),
         .dn_quo   (dv_quo[k+1]),
         .dn_side  (dv_side[k+1])
      );
   end

   assign {dq_q[0], dq_q[1], dq_q[2], dq_s[0], dq_s[1], dq_s[2], dq_d[0], dq_d[1], dq_d[2],
           dq_ok, dq_neg, dq_degen, dq_ovf} = dv_side[CW];

   // stage t: clamp to the signed range, then apply the sign
   always_comb begin
      t_lim     = dq_neg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      st_mag_in = (dq_ovf || dv_quo[CW] > t_lim) ? t_lim : dv_quo[CW];
      st_t_in   = dq_neg ? -$signed(st_mag_in) : $signed(st_mag_in);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            st_q_ff[i] <= dq_q[i];
            st_s_ff[i] <= dq_s[i];
            st_d_ff[i] <= dq_d[i];
         end
         st_mag_ff   <= st_mag_in;
         st_t_ff     <= st_t_in;
         st_neg_ff   <= dq_neg;
         st_ok_ff    <= dq_ok;
         st_degen_ff <= dq_degen;
      end
   end

   // stage m: |t| * |d| per axis
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d_mag[i] = st_d_ff[i][DW-1] ? DW'(-st_d_ff[i]) : DW'(st_d_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            sm_q_ff[i]    <= st_q_ff[i];
            sm_s_ff[i]    <= st_s_ff[i];
            sm_dneg_ff[i] <= st_d_ff[i][DW-1];
            sm_p_ff[i]    <= (CW+DW)'(st_mag_ff) * (CW+DW)'(d_mag[i]);
         end
         sm_t_ff     <= st_t_ff;
         sm_neg_ff   <= st_neg_ff;
         sm_ok_ff    <= st_ok_ff;
         sm_degen_ff <= st_degen_ff;
      end
   end

   // stage n: round the offset, cap it well past the coordinate range, add and saturate
   always_comb begin
      off_cap = MW'(1) << (CW + 1);
      for (int i = 0; i < 3; i++) begin
         p_rnd[i]   = (CW+DW+1)'(sm_p_ff[i]) + ((CW+DW+1)'(1) << (FB - 1));
         off_ext[i] = MW'(p_rnd[i] >> FB);
         off_mag[i] = (off_ext[i] > off_cap) ? off_cap[CW+1:0] : off_ext[i][CW+1:0];
         near_sum[i] = (sm_neg_ff ^ sm_dneg_ff[i])
                     ? NSW'(sm_s_ff[i]) - $signed({1'b0, off_mag[i]})
                     : NSW'(sm_s_ff[i]) + $signed({1'b0, off_mag[i]});
         if ((&near_sum[i][NSW-1:CW-1]) || !(|near_sum[i][NSW-1:CW-1])) begin
            sn_near_in[i] = near_sum[i][CW-1:0];
         end else begin
            sn_near_in[i] = near_sum[i][NSW-1] ? {1'b1, {(CW-1){1'b0}}}
                                               : {1'b0, {(CW-1){1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            sn_q_ff[i]    <= sm_q_ff[i];
            sn_near_ff[i] <= sn_near_in[i];
         end
         sn_t_ff     <= sm_t_ff;
         sn_ok_ff    <= sm_ok_ff;
         sn_degen_ff <= sm_degen_ff;
      end
   end

   // stage e: squared error per axis against the unrestricted closest point
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         err[i]     = DW'(sn_q_ff[i]) - DW'(sn_near_ff[i]);
         err_mag[i] = err[i][DW-1] ? DW'(-err[i]) : DW'(err[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            se_sq_ff[i]   <= PW'(err_mag[i]) * PW'(err_mag[i]);
            se_near_ff[i] <= sn_near_ff[i];
         end
         se_t_ff     <= sn_t_ff;
         se_ok_ff    <= sn_ok_ff;
         se_degen_ff <= sn_degen_ff;
      end
   end

   // stage d: distance squared; anything at or above 2^(2*CW) saturates the root
   assign dist2 = (PW+2)'(se_sq_ff[0]) + (PW+2)'(se_sq_ff[1]) + (PW+2)'(se_sq_ff[2]);

   always_ff @(posedge clock) begin
      if (adv) begin
         sd_rad_ff  <= dist2[2*CW-1:0];
         sd_side_ff <= {se_t_ff, se_near_ff[0], se_near_ff[1], se_near_ff[2], se_ok_ff,
                        se_degen_ff, |dist2[PW+1:2*CW]};
      end
   end

   assign sq_valid[0] = vd_ff;
   assign sq_rem[0]   = '0;
   assign sq_root[0]  = '0;
   assign sq_rad[0]   = sd_rad_ff;
   assign sq_side[0]  = sd_side_ff;

   for (genvar k = 0; k < CW; k++) begin : g_sqrt
      ptlp_sqrt_cell #(.ROOT_W(CW), .SB_W(QSB)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (adv),
         .up_valid (sq_valid[k]),
         .up_rem   (sq_rem[k]),
         .up_root  (sq_root[k]),
         .up_rad   (sq_rad[k]),
         .up_side  (sq_side[k]),
         .dn_valid (sq_valid[k+1]),
         .dn_rem   (sq_rem[k+1]),
         .dn_root  (sq_root[k+1]),
         .dn_rad   (sq_rad[k+1]),
         .dn_side  (sq_side[k+1])
      );
   end

   assign {fq_t, fq_near[0], fq_near[1], fq_near[2], fq_ok, fq_degen, fq_sat} = sq_side[CW];

   // output register: degenerate zeroes everything, a rejected point zeroes the coordinates
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            out_near_ff[i] <= (fq_ok && !fq_degen) ? fq_near[i] : '0;
         end
         out_t_ff     <= fq_degen ? '0 : fq_t;
         out_ok_ff    <= fq_ok && !fq_degen;
         out_degen_ff <= fq_degen;
         out_dist_ff  <= fq_degen ? '0 : (fq_sat ? '1 : sq_root[CW]);
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.line_param    = out_t_ff;
   assign rsp_chan.near_x        = out_near_ff[0];
   assign rsp_chan.near_y        = out_near_ff[1];
   assign rsp_chan.near_z        = out_near_ff[2];
   assign rsp_chan.near_valid    = out_ok_ff;
   assign rsp_chan.line_distance = out_dist_ff;
   assign rsp_chan.degenerate    = out_degen_ff;
endmodule

### rtl/ptlp_checker.sv
// port level checks of the projection block, bound to the top level
`timescale 1ns / 1ps
module ptlp_checker import ptlp_pkg::*; #(parameter int CW = DEF_COORD_WIDTH) (
   input logic          clock,
   input logic          reset,
   input logic          req_ready,
   input logic          rsp_valid,
   input logic          rsp_ready,
   input logic [CW-1:0] line_param,
   input logic [CW-1:0] near_x,
   input logic [CW-1:0] near_y,
   input logic [CW-1:0] near_z,
   input logic          near_valid,
   input logic [CW-1:0] line_distance,
   input logic          degenerate
);
   // a waiting response keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(line_param) && $stable(line_distance))
      else $error("stalled response changed");

   // a full, stalled output stops new requests
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while output is blocked");

   // coinciding line points give all-zero results
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && degenerate |-> line_param == '0 && !near_valid && line_distance == '0)
      else $error("degenerate response carries results");

   // a withheld closest point reads as zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !near_valid |-> near_x == '0 && near_y == '0 && near_z == '0)
      else $error("withheld closest point is not zero");
endmodule

bind point_to_line_projection ptlp_checker #(.CW(COORD_WIDTH)) u_ptlp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .line_param    (rsp_chan.line_param),
   .near_x        (rsp_chan.near_x),
   .near_y        (rsp_chan.near_y),
   .near_z        (rsp_chan.near_z),
   .near_valid    (rsp_chan.near_valid),
   .line_distance (rsp_chan.line_distance),
   .degenerate    (rsp_chan.degenerate)
);

### dv/ptlp_checker.sv
// scoreboard for the projection block: predicts each response and compares it
`timescale 1ns / 1ps
module ptlp_scoreboard import ptlp_pkg::*; (
   input  logic clock,
   input  logic reset,
   ptlp_req_if  req_mon,
   ptlp_rsp_if  rsp_mon,
   output int   error_count,
   output int   pending_count
);
   localparam int CW = DEF_COORD_WIDTH;
   localparam int FB = DEF_FRAC_BITS;

   typedef struct packed {
      logic signed [CW-1:0] line_param;
      logic signed [CW-1:0] near_x;
      logic signed [CW-1:0] near_y;
      logic signed [CW-1:0] near_z;
      logic                 near_valid;
      logic [CW-1:0]        line_distance;
      logic                 degenerate;
   } proj_type;

   proj_type projections_due[$];

   function automatic longint unsigned abs64(longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   function automatic longint sat_coord(longint v);
      longint hi, lo;
      hi = (longint'(1) <<< (CW - 1)) - 1;
      lo = -hi - 1;
      return (v > hi) ? hi : ((v < lo) ? lo : v);
   endfunction

   // exact projection: wide integer dot products, rounded divide, floor root
   function automatic proj_type project(longint q[3], longint s[3], longint e[3], logic seg);
      proj_type             r;
      longint               d[3], w[3], tv, off, nr[3], err;
      logic signed [127:0]  num, den, wi, di;
      logic [127:0]         nmag, dmag, qt, p, dist2, c;
      longint unsigned      lim, dm, root;
      logic                 neg, valid;
      r = '0;
      num = 0;
      den = 0;
      for (int i = 0; i < 3; i++) begin
         d[i] = e[i] - s[i];
         w[i] = q[i] - s[i];
         wi = w[i];
         di = d[i];
         num = num + wi * di;
         den = den + di * di;
      end
      if (den == 0) begin
         r.degenerate = 1'b1;
         return r;
      end
      neg = num < 0;
      nmag = neg ? -num : num;
      dmag = den;
      valid = !(seg && (neg || nmag > dmag));
      qt = ((nmag << FB) + (dmag >> 1)) / dmag;
      lim = (64'd1 << (CW - 1)) - (neg ? 64'd0 : 64'd1);
      if (qt > lim) qt = lim;
      tv = neg ? -longint'(qt[63:0]) : longint'(qt[63:0]);
      dist2 = 0;
      for (int i = 0; i < 3; i++) begin
         p = (128'(abs64(tv)) * 128'(abs64(d[i])) + (128'd1 << (FB - 1))) >> FB;
         dm = (p > (128'd1 << 62)) ? (64'd1 << 62) : p[63:0];
         off = ((tv < 0) != (d[i] < 0)) ? -longint'(dm) : longint'(dm);
         nr[i] = sat_coord(s[i] + off);
         err = q[i] - nr[i];
         dist2 = dist2 + 128'(abs64(err)) * 128'(abs64(err));
      end
      root = 0;
      for (int b = 63; b >= 0; b--) begin
         c = 128'(root | (64'd1 << b));
         if (c * c <= dist2) root = c[63:0];
      end
      r.line_param = tv[CW-1:0];
      if (valid) begin
         r.near_x = nr[0][CW-1:0];
         r.near_y = nr[1][CW-1:0];
         r.near_z = nr[2][CW-1:0];
         r.near_valid = 1'b1;
      end
      r.line_distance = (root > {CW{1'b1}}) ? {CW{1'b1}} : root[CW-1:0];
      return r;
   endfunction

   task automatic check_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         $error("%s mismatch: expected %0d actual %0d", name, exp_v, act_v);
         error_count++;
      end
   endtask

   initial begin
      error_count = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      proj_type got, want;
      longint   q[3], s[3], e[3];
      if (!reset) begin
         if (req_mon.valid && req_mon.ready) begin
            q = '{req_mon.query_x, req_mon.query_y, req_mon.query_z};
            s = '{req_mon.start_x, req_mon.start_y, req_mon.start_z};
            e = '{req_mon.end_x, req_mon.end_y, req_mon.end_z};
            projections_due.push_back(project(q, s, e, req_mon.segment_only));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.line_param, rsp_mon.near_x, rsp_mon.near_y, rsp_mon.near_z,
                    rsp_mon.near_valid, rsp_mon.line_distance, rsp_mon.degenerate};
            if (projections_due.size() == 0) begin
               $error("response with no request outstanding");
               error_count++;
            end else begin
               want = projections_due.pop_front();
               check_field("line_param", want.line_param, got.line_param);
               check_field("near_x", want.near_x, got.near_x);
               check_field("near_y", want.near_y, got.near_y);
               check_field("near_z", want.near_z, got.near_z);
               check_field("near_valid", want.near_valid, got.near_valid);
               check_field("line_distance", want.line_distance, got.line_distance);
               check_field("degenerate", want.degenerate, got.degenerate);
            end
         end
         pending_count = projections_due.size();
      end
   end
endmodule

### dv/tb_point_to_line_projection.sv
// testbench top for the point to line projection block
`timescale 1ns / 1ps
module tb_point_to_line_projection;
   import ptlp_pkg::*;

   localparam int CW       = DEF_COORD_WIDTH;
   localparam int PIPE_LAT = 2 * CW + 11;
   localparam int MAX_POS  = 32'h7fff_ffff;
   localparam int MIN_NEG  = 32'h8000_0000;
   localparam int ONE      = 1 << DEF_FRAC_BITS;

   logic clock;
   logic reset;
   int   error_count;
   int   pending_count;

   // idle percentages per phase, owned by the stimulus process
   int   send_idle_pct;
   int   rsp_stall_pct;
   // long receiver hold-offs: stimulus bumps the request, ready process serves it
   int   hold_asked;
   int   hold_done;

   ptlp_req_if req_chan ();
   ptlp_rsp_if rsp_chan ();

   point_to_line_projection i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   ptlp_scoreboard i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always #10 clock = ~clock;

   // response ready: random stalls, plus the long hold-off when asked
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && hold_asked != hold_done) begin
            hold_left = 400;
            hold_done = hold_done + 1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // one coordinate: mostly small values so geometry stays meaningful, some full range
   function automatic logic [CW-1:0] rand_coord();
      case ($urandom_range(9))
         0, 1:    return $urandom;
         2:       return $urandom_range(1) ? MAX_POS : MIN_NEG;
         3, 4, 5: return int'($urandom_range(2 * 64 * ONE)) - 64 * ONE;
         default: return int'($urandom_range(2 * 4096 * ONE)) - 4096 * ONE;
      endcase
   endfunction

   // offer one request at the falling edge and hold it until taken
   task automatic send_request(logic [CW-1:0] qx, qy, qz, sx, sy, sz, ex, ey, ez,
                               logic seg);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
      end
      @(negedge clock);
      req_chan.valid        <= 1'b1;
      req_chan.query_x      <= qx;
      req_chan.query_y      <= qy;
      req_chan.query_z      <= qz;
      req_chan.start_x      <= sx;
      req_chan.start_y      <= sy;
      req_chan.start_z      <= sz;
      req_chan.end_x        <= ex;
      req_chan.end_y        <= ey;
      req_chan.end_z        <= ez;
      req_chan.segment_only <= seg;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
   endtask

   // random request: mostly proper lines, some degenerate or collinear queries
   task automatic send_random();
      logic [CW-1:0] qx, qy, qz, sx, sy, sz, ex, ey, ez;
      qx = rand_coord(); qy = rand_coord(); qz = rand_coord();
      sx = rand_coord(); sy = rand_coord(); sz = rand_coord();
      ex = rand_coord(); ey = rand_coord(); ez = rand_coord();
      case ($urandom_range(19))
         0: begin
            // start equals end
            ex = sx; ey = sy; ez = sz;
         end
         1: begin
            // query sits on an end point
            qx = ex; qy = ey; qz = ez;
         end
         2: begin
            // one-lsb direction, t saturates easily
            ex = sx + 1; ey = sy; ez = sz;
         end
         default: ;
      endcase
      send_request(qx, qy, qz, sx, sy, sz, ex, ey, ez, 1'($urandom_range(1)));
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_asked = 0;
      hold_done = 0;
      req_chan.valid = 1'b0;
      req_chan.query_x = '0;
      req_chan.query_y = '0;
      req_chan.query_z = '0;
      req_chan.start_x = '0;
      req_chan.start_y = '0;
      req_chan.start_z = '0;
      req_chan.end_x = '0;
      req_chan.end_y = '0;
      req_chan.end_z = '0;
      req_chan.segment_only = 1'b0;
      rsp_chan.ready = 1'b0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // directed: degenerate lines, extremes, segment edges, rounding ties
      send_request(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_request(MAX_POS, MIN_NEG, 5, 3, 3, 3, 3, 3, 3, 1);
      send_request(MAX_POS, MAX_POS, MAX_POS, MIN_NEG, MIN_NEG, MIN_NEG,
                   MAX_POS, MAX_POS, MAX_POS, 0);
      send_request(MIN_NEG, MIN_NEG, MIN_NEG, MIN_NEG, MIN_NEG, MIN_NEG,
                   MAX_POS, MAX_POS, MAX_POS, 1);
      send_request(MIN_NEG, MAX_POS, MIN_NEG, MAX_POS, MIN_NEG, MAX_POS,
                   MIN_NEG, MAX_POS, MIN_NEG, 1);
      send_request(MAX_POS, 0, 0, 0, 0, 0, 1, 0, 0, 0);
      send_request(MIN_NEG, 0, 0, 0, 0, 0, 1, 0, 0, 1);
      send_request(MAX_POS, MAX_POS, 0, MIN_NEG, 0, 0, MIN_NEG + 1, 0, 0, 0);
      send_request(0, ONE, 0, 0, 0, 0, ONE, 0, 0, 1);
      send_request(ONE, ONE, 0, 0, 0, 0, ONE, 0, 0, 1);
      send_request(2 * ONE, ONE, 0, 0, 0, 0, ONE, 0, 0, 1);
      send_request(-ONE, ONE, 0, 0, 0, 0, ONE, 0, 0, 1);
      send_request(2 * ONE, ONE, 0, 0, 0, 0, ONE, 0, 0, 0);
      send_request(-ONE, -ONE, 0, 0, 0, 0, ONE, 0, 0, 0);
      send_request(1, 0, 0, 0, 0, 0, 2, 0, 0, 1);
      send_request(-1, 0, 0, 0, 0, 0, 2, 0, 0, 0);
      send_request(ONE / 2, 7, -9, 0, 0, 0, 3 * ONE, 0, 0, 1);
      send_request(5, 5, 5, -1, -1, -1, 1, 1, 1, 1);
      send_request(MAX_POS, MAX_POS, MAX_POS, 0, 0, 0, -1, -1, -1, 0);
      send_request(32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f, 32'hf0f0_f0f0,
                   32'h3333_3333, 32'hcccc_cccc, 32'h0000_ffff, 32'hffff_0000, 7, 1);

      // random phases: no idling apart from one long receiver hold-off, sender idle, receiver stall, both
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1) ? 62 : ((phase == 3) ? 28 : 0);
         rsp_stall_pct = (phase == 2) ? 62 : ((phase == 3) ? 28 : 0);
         if (phase == 0) hold_asked = hold_asked + 1;
         for (int n = 0; n < 420; n++) send_random();
      end

      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (PIPE_LAT + 20) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // watchdog
   initial begin
      #20ms;
      $display("DONE: errors detected");
      $finish;
   end
endmodule
